[design/skgf_pkg.sv]
// shared widths, fixed-point constants and register map of the scalar kalman gap filler
// no dependencies; imported by the interfaces and the top level
`timescale 1ns / 1ps

package skgf_pkg;

  localparam int SAMPLE_W = 32;            // signed Q15.16 samples and estimates
  localparam int P_W      = 32;            // uncertainty, unsigned Q16.16
  localparam int CFG_W    = 24;            // noise and start uncertainty, unsigned Q8.16
  localparam int RC_W     = 11;            // repeat count on the result
  localparam int K_W      = 17;            // gain, unsigned Q1.16 up to 1.0
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  localparam logic [K_W-1:0] ONE_Q16 = 17'h1_0000;

  localparam int MAX_REPEAT_DEF = 1024;

  localparam logic [CFG_W-1:0] PROC_NOISE_RST = 24'd6554;
  localparam logic [CFG_W-1:0] MEAS_NOISE_RST = 24'd32768;
  localparam logic [CFG_W-1:0] INIT_UNC_RST   = 24'd65536;

  typedef enum logic [1:0] {
    REG_PROC_NOISE = 2'd0,
    REG_MEAS_NOISE = 2'd1,
    REG_INIT_UNC   = 2'd2
  } cfg_reg_e;

endpackage

[design/skgf_if.sv]
// valid/ready channel interfaces for input samples and filtered results
// depends on skgf_pkg for field widths
`timescale 1ns / 1ps

interface skgf_in_if import skgf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       missing;
  logic                       last_sample;

  modport source (output valid, output sample, output missing, output last_sample,
                  input ready);
  modport sink   (input valid, input sample, input missing, input last_sample,
                  output ready);
endinterface

interface skgf_out_if import skgf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] estimate;
  logic [RC_W-1:0]            repeat_count;
  logic                       imputed;
  logic                       column_end;

  modport source (output valid, output estimate, output repeat_count, output imputed,
                  output column_end, input ready);
  modport sink   (input valid, input estimate, input repeat_count, input imputed,
                  input column_end, output ready);
endinterface

[design/scalar_kalman_gap_filler_top.sv]
// scalar kalman gap filler: one column of Q15.16 samples filtered, gaps imputed
// depends on skgf_pkg and the channel interfaces in skgf_if.sv
`timescale 1ns / 1ps

// A measured sample passes through the accept state, 17 steps of the radix-2 divider that
// forms the gain p/(p+r), then the shared 18x33 multiplier (estimate correction, then
// uncertainty shrink) and a finishing state. A missing sample goes from the accept state
// straight to the finishing state. The input is not ready while an item is in work; a
// result sits in an output register, so the next item is taken while it waits. Leading
// gaps of a column give no beat; the first measured sample carries their count. The
// beat for the item marked last_sample has column_end set and the state restarts.
module scalar_kalman_gap_filler_top import skgf_pkg::*; #(
  parameter int MAX_REPEAT = MAX_REPEAT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  skgf_in_if.sink           in_i,
  skgf_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int GW = $clog2(MAX_REPEAT);
  localparam int CW = (GW + 1 > RC_W) ? GW + 1 : RC_W;
  localparam logic [GW-1:0] GAP_MAX = GW'(MAX_REPEAT - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MULX,
    ST_MULP,
    ST_FIN
  } state_e;

  state_e                     state_q;
  logic [CFG_W-1:0]           proc_q, meas_q, init_q;
  logic signed [SAMPLE_W-1:0] x_q, smp_q;
  logic [P_W-1:0]             p_q, pp_q;
  logic                       seen_q, miss_q, last_q;
  logic [GW-1:0]              gap_q;
  logic [RC_W-1:0]            cnt_q;
  logic [P_W:0]               den_q;
  logic [P_W+1:0]             rem_q;
  logic [K_W-1:0]             k_q;
  logic [4:0]                 step_q;
  logic signed [50:0]         prod_q;

  logic                       out_valid_q, imp_q, col_end_q;
  logic signed [SAMPLE_W-1:0] est_q;
  logic [RC_W-1:0]            rc_q;

  // register port
  cfg_reg_e cfg_idx;
  logic     cfg_wr;
  assign cfg_idx = cfg_reg_e'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_comb begin
    unique case (cfg_idx)
      REG_PROC_NOISE: prdata = APB_DW'(proc_q);
      REG_MEAS_NOISE: prdata = APB_DW'(meas_q);
      REG_INIT_UNC:   prdata = APB_DW'(init_q);
      default:        prdata = '0;
    endcase
  end

  // predicted uncertainty, saturating
  logic [P_W:0]   pp_sum;
  logic [P_W-1:0] pp_d;
  assign pp_sum = {1'b0, p_q} + (P_W + 1)'(proc_q);
  assign pp_d   = pp_sum[P_W] ? '1 : pp_sum[P_W-1:0];

  logic [CW-1:0] cnt_first;
  assign cnt_first = CW'(gap_q) + CW'(1);

  // divider step: one quotient bit a cycle
  logic [P_W+1:0] div_sh, div_sub;
  logic           div_ge;
  assign div_sh  = (step_q == '0) ? rem_q : {rem_q[P_W:0], 1'b0};
  assign div_ge  = div_sh >= {1'b0, den_q};
  assign div_sub = div_sh - {1'b0, den_q};

  // shared multiplier
  logic [SAMPLE_W:0]  diff;
  logic signed [17:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [50:0] mul_p;
  logic [K_W-1:0]     one_minus_k;
  assign diff        = {smp_q[SAMPLE_W-1], smp_q} - {x_q[SAMPLE_W-1], x_q};
  assign one_minus_k = ONE_Q16 - k_q;

  always_comb begin
    if (state_q == ST_MULX) begin
      mul_a = $signed({1'b0, k_q});
      mul_b = $signed(diff);
    end else begin
      mul_a = $signed({1'b0, one_minus_k});
      mul_b = $signed({1'b0, pp_q});
    end
  end
  assign mul_p = mul_a * mul_b;

  logic in_acc, emit, fin_go;
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid & in_i.ready;
  assign emit       = !miss_q || seen_q;
  assign fin_go     = !emit || !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      proc_q      <= PROC_NOISE_RST;
      meas_q      <= MEAS_NOISE_RST;
      init_q      <= INIT_UNC_RST;
      x_q         <= '0;
      p_q         <= P_W'(INIT_UNC_RST);
      seen_q      <= 1'b0;
      gap_q       <= '0;
      smp_q       <= '0;
      pp_q        <= '0;
      miss_q      <= 1'b0;
      last_q      <= 1'b0;
      cnt_q       <= '0;
      den_q       <= '0;
      rem_q       <= '0;
      k_q         <= '0;
      step_q      <= '0;
      prod_q      <= '0;
      out_valid_q <= 1'b0;
      est_q       <= '0;
      rc_q        <= '0;
      imp_q       <= 1'b0;
      col_end_q   <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_PROC_NOISE: proc_q <= pwdata[CFG_W-1:0];
          REG_MEAS_NOISE: meas_q <= pwdata[CFG_W-1:0];
          REG_INIT_UNC: begin
            init_q <= pwdata[CFG_W-1:0];
            // column untouched so far: takes effect at once
            if (!seen_q && gap_q == '0) begin
              p_q <= P_W'(pwdata[CFG_W-1:0]);
            end
          end
          default: ;
        endcase
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            smp_q  <= in_i.sample;
            miss_q <= in_i.missing;
            last_q <= in_i.last_sample;
            pp_q   <= pp_d;
            den_q  <= {1'b0, pp_d} + (P_W + 1)'(meas_q);
            rem_q  <= (P_W + 2)'(pp_d);
            k_q    <= '0;
            step_q <= '0;
            cnt_q  <= RC_W'(1);
            if (in_i.missing) begin
              state_q <= ST_FIN;
            end else begin
              if (!seen_q) begin
                x_q    <= in_i.sample;
                seen_q <= 1'b1;
                cnt_q  <= cnt_first[RC_W-1:0];
              end
              state_q <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          rem_q  <= div_ge ? div_sub : div_sh;
          k_q    <= {k_q[K_W-2:0], div_ge};
          step_q <= step_q + 5'd1;
          if (step_q == 5'(K_W - 1)) begin
            // zero divisor: no correction
            if (den_q == '0) begin
              k_q <= '0;
            end
            state_q <= ST_MULX;
          end
        end
        ST_MULX: begin
          prod_q  <= mul_p;
          state_q <= ST_MULP;
        end
        ST_MULP: begin
          // floor of k*diff/2^16 added, exact modulo 2^32
          x_q     <= x_q + $signed(prod_q[47:16]);
          prod_q  <= mul_p;
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (fin_go) begin
            if (emit) begin
              out_valid_q <= 1'b1;
              est_q       <= x_q;
              rc_q        <= cnt_q;
              imp_q       <= miss_q;
              col_end_q   <= last_q;
            end
            if (miss_q) begin
              p_q <= pp_q;
              if (!seen_q && gap_q < GAP_MAX) begin
                gap_q <= gap_q + GW'(1);
              end
            end else begin
              p_q <= prod_q[47:16];
            end
            if (last_q) begin
              x_q    <= '0;
              p_q    <= P_W'(init_q);
              seen_q <= 1'b0;
              gap_q  <= '0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.estimate     = est_q;
  assign out_o.repeat_count = rc_q;
  assign out_o.imputed      = imp_q;
  assign out_o.column_end   = col_end_q;

  // gain never exceeds one once the divider is done
  a_gain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MULX |-> k_q <= ONE_Q16)
    else $error("gain above one");

  // a measurement never raises the uncertainty above its prediction
  a_unc_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && !miss_q) |-> prod_q[47:16] <= pp_q)
    else $error("uncertainty grew on a measured sample");

  // the column restarts after its last item
  a_col_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && fin_go && last_q) |=>
      (!seen_q && gap_q == '0 && x_q == '0 && state_q == ST_IDLE))
    else $error("column state not cleared after last sample");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && emit && out_valid_q && !out_o.ready) |=> state_q == ST_FIN)
    else $error("result register overwritten");

endmodule
